// File: sv/prmm_pkg.sv
`timescale 1ns / 1ps

package prmm_pkg;

  // Word width of one lane.
  localparam int unsigned WordW = 32;

  // Math selector reduction: 2^10 is 1 modulo 11, so 10-bit chunks add up.
  localparam int unsigned MathMod     = 11;
  localparam int unsigned MathSumW    = 12;
  localparam int unsigned Mod11Recip  = 186;  // floor(2^11 / 11) - 0, below 1/11
  localparam int unsigned Mod11Shift  = 11;

  // Merge rotate reduction: 2^5 is 1 modulo 31, so 5-bit chunks add up.
  localparam int unsigned RotMod      = 31;
  localparam int unsigned RotSumW     = 7;
  localparam int unsigned RotW        = 5;

  // Math operation codes, math_select modulo 11.
  typedef enum logic [3:0] {
    MOP_ADD    = 4'd0,
    MOP_MULLO  = 4'd1,
    MOP_MULHI  = 4'd2,
    MOP_MIN    = 4'd3,
    MOP_ROTL   = 4'd4,
    MOP_ROTR   = 4'd5,
    MOP_AND    = 4'd6,
    MOP_OR     = 4'd7,
    MOP_XOR    = 4'd8,
    MOP_CLZSUM = 4'd9,
    MOP_POPSUM = 4'd10
  } math_op_e;

  // Merge codes, merge_select modulo 4.
  typedef enum logic [1:0] {
    MRG_MAC33  = 2'd0,
    MRG_XOR33  = 2'd1,
    MRG_ROTL   = 2'd2,
    MRG_ROTR   = 2'd3
  } merge_op_e;

  // Rotate left by n, n taken modulo 32.
  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] v,
                                               input logic [RotW-1:0] n);
    logic [2*WordW-1:0] x;
    x = {v, v} << n;
    return x[2*WordW-1:WordW];
  endfunction

  // Rotate right by n, n taken modulo 32.
  function automatic logic [WordW-1:0] rotr32(input logic [WordW-1:0] v,
                                               input logic [RotW-1:0] n);
    logic [2*WordW-1:0] x;
    x = {v, v} >> n;
    return x[WordW-1:0];
  endfunction

endpackage

// File: sv/prmm_alu.sv
`timescale 1ns / 1ps

// Non-multiplying math operations of one lane. The multiply codes return zero
// here; their product comes from the multiplier beside this unit.
module prmm_alu (
  input  logic [prmm_pkg::WordW-1:0] src_a_i,
  input  logic [prmm_pkg::WordW-1:0] src_b_i,
  input  prmm_pkg::math_op_e         op_i,
  output logic [prmm_pkg::WordW-1:0] result_o
);

  localparam int unsigned CntW = $clog2(prmm_pkg::WordW + 1);

  logic [CntW-1:0] clz_a;
  logic [CntW-1:0] clz_b;
  logic [CntW-1:0] pop_a;
  logic [CntW-1:0] pop_b;

  // Leading zeros as a priority encoder; a zero word counts the full width.
  always_comb begin
    clz_a = CntW'(prmm_pkg::WordW);
    clz_b = CntW'(prmm_pkg::WordW);
    for (int i = 0; i < prmm_pkg::WordW; i++) begin
      if (src_a_i[i]) begin
        clz_a = CntW'(prmm_pkg::WordW - 1 - i);
      end
      if (src_b_i[i]) begin
        clz_b = CntW'(prmm_pkg::WordW - 1 - i);
      end
    end
  end

  // Population counts, summed bit by bit.
  always_comb begin
    pop_a = '0;
    pop_b = '0;
    for (int i = 0; i < prmm_pkg::WordW; i++) begin
      pop_a = pop_a + CntW'(src_a_i[i]);
      pop_b = pop_b + CntW'(src_b_i[i]);
    end
  end

  // Operation select.
  always_comb begin
    unique case (op_i)
      prmm_pkg::MOP_ADD: begin
        result_o = src_a_i + src_b_i;
      end
      prmm_pkg::MOP_MIN: begin
        result_o = (src_a_i < src_b_i) ? src_a_i : src_b_i;
      end
      prmm_pkg::MOP_ROTL: begin
        result_o = prmm_pkg::rotl32(src_a_i, src_b_i[prmm_pkg::RotW-1:0]);
      end
      prmm_pkg::MOP_ROTR: begin
        result_o = prmm_pkg::rotr32(src_a_i, src_b_i[prmm_pkg::RotW-1:0]);
      end
      prmm_pkg::MOP_AND: begin
        result_o = src_a_i & src_b_i;
      end
      prmm_pkg::MOP_OR: begin
        result_o = src_a_i | src_b_i;
      end
      prmm_pkg::MOP_XOR: begin
        result_o = src_a_i ^ src_b_i;
      end
      prmm_pkg::MOP_CLZSUM: begin
        result_o = prmm_pkg::WordW'(clz_a) + prmm_pkg::WordW'(clz_b);
      end
      prmm_pkg::MOP_POPSUM: begin
        result_o = prmm_pkg::WordW'(pop_a) + prmm_pkg::WordW'(pop_b);
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// File: sv/progpow_random_math_merge.sv
// Pipeline: a result passes the stage one, stage two and output registers.
// Throughput: one transaction per cycle while m_axis_tready_i is high; the 32x32 multiplier in stage two
// and the merge adders in stage three set the cycle time.
// Stalls propagate stage by stage, so empty stages still accept input.
// Reset (asynchronous, active low) clears the stage valid bits only.
`timescale 1ns / 1ps

module progpow_random_math_merge (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: dst_value, src_a, src_b, math_select, merge_select.
  input  logic [159:0] s_axis_tdata_i,
  // tuser: cmd.
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: merged_value.
  output logic [31:0]  m_axis_tdata_o
);

  localparam int unsigned W     = prmm_pkg::WordW;
  localparam int unsigned SumW  = prmm_pkg::MathSumW;
  localparam int unsigned RSumW = prmm_pkg::RotSumW;
  localparam int unsigned RW    = prmm_pkg::RotW;
  localparam int unsigned PrW   = SumW + 9;
  localparam int unsigned QW    = PrW - prmm_pkg::Mod11Shift;

  // Input field unpacking.
  logic [W-1:0] in_dst;
  logic [W-1:0] in_a;
  logic [W-1:0] in_b;
  logic [W-1:0] in_msel;
  logic [W-1:0] in_gsel;

  assign in_dst  = s_axis_tdata_i[W-1:0];
  assign in_a    = s_axis_tdata_i[2*W-1:W];
  assign in_b    = s_axis_tdata_i[3*W-1:2*W];
  assign in_msel = s_axis_tdata_i[4*W-1:3*W];
  assign in_gsel = s_axis_tdata_i[5*W-1:4*W];

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v3_q;

  // Stage one: chunk sums for both selector reductions.
  logic [SumW-1:0]  msum_d;
  logic [RSumW-1:0] rsum_d;

  assign msum_d = SumW'(in_msel[9:0]) + SumW'(in_msel[19:10])
                + SumW'(in_msel[29:20]) + SumW'(in_msel[31:30]);
  assign rsum_d = RSumW'(in_gsel[20:16]) + RSumW'(in_gsel[25:21])
                + RSumW'(in_gsel[30:26]) + RSumW'(in_gsel[31]);

  logic             s1_cmd_q;
  logic [W-1:0]     s1_dst_q, s1_a_q, s1_b_q;
  logic [SumW-1:0]  s1_msum_q;
  logic [RSumW-1:0] s1_rsum_q;
  logic [1:0]       s1_gop_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_cmd_q  <= s_axis_tuser_i;
      s1_dst_q  <= in_dst;
      s1_a_q    <= in_a;
      s1_b_q    <= in_b;
      s1_msum_q <= msum_d;
      s1_rsum_q <= rsum_d;
      s1_gop_q  <= in_gsel[1:0];
    end
  end

  // Stage two: finish modulo 11 by reciprocal and one correction.
  logic [PrW-1:0]  mprod;
  logic [QW-1:0]   mquot;
  logic [SumW-1:0] mrem_full;
  logic [4:0]      mrem;
  logic [3:0]      mop_code;
  prmm_pkg::math_op_e op_d;

  assign mprod     = PrW'(s1_msum_q) * PrW'(prmm_pkg::Mod11Recip);
  assign mquot     = mprod[PrW-1:prmm_pkg::Mod11Shift];
  assign mrem_full = s1_msum_q - SumW'(SumW'(mquot) * SumW'(prmm_pkg::MathMod));
  assign mrem      = mrem_full[4:0];
  assign mop_code  = (mrem >= 5'(prmm_pkg::MathMod)) ? 4'(mrem - 5'(prmm_pkg::MathMod))
                                                      : mrem[3:0];
  assign op_d      = prmm_pkg::math_op_e'(mop_code);

  // Finish modulo 31 of the rotate field and add one.
  logic [5:0]    rfold;
  logic [5:0]    rmod;
  logic [RW-1:0] rot_d;

  assign rfold = 6'(s1_rsum_q[4:0]) + 6'(s1_rsum_q[6:5]);
  assign rmod  = (rfold >= 6'(prmm_pkg::RotMod)) ? rfold - 6'(prmm_pkg::RotMod) : rfold;
  assign rot_d = rmod[RW-1:0] + RW'(1);

  // Math units: the ALU and the 32x32 multiplier.
  logic [W-1:0]   alu_d;
  logic [2*W-1:0] prod_d;

  prmm_alu u_alu (
    .src_a_i  (s1_a_q),
    .src_b_i  (s1_b_q),
    .op_i     (op_d),
    .result_o (alu_d)
  );

  assign prod_d = (2*W)'(s1_a_q) * (2*W)'(s1_b_q);

  logic               s2_cmd_q;
  logic [W-1:0]       s2_dst_q, s2_a_q, s2_alu_q;
  logic [2*W-1:0]     s2_prod_q;
  prmm_pkg::math_op_e s2_op_q;
  logic [RW-1:0]      s2_rot_q;
  prmm_pkg::merge_op_e s2_gop_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_dst_q  <= s1_dst_q;
      s2_a_q    <= s1_a_q;
      s2_alu_q  <= alu_d;
      s2_prod_q <= prod_d;
      s2_op_q   <= op_d;
      s2_rot_q  <= rot_d;
      s2_gop_q  <= prmm_pkg::merge_op_e'(s1_gop_q);
    end
  end

  // Stage three: pick the merge data, then merge into the destination.
  logic [W-1:0] data;
  logic [W-1:0] merged_d;

  always_comb begin
    priority if (s2_cmd_q) begin
      data = s2_a_q;
    end else if (s2_op_q == prmm_pkg::MOP_MULLO) begin
      data = s2_prod_q[W-1:0];
    end else if (s2_op_q == prmm_pkg::MOP_MULHI) begin
      data = s2_prod_q[2*W-1:W];
    end else begin
      data = s2_alu_q;
    end
  end

  always_comb begin
    unique case (s2_gop_q)
      prmm_pkg::MRG_MAC33: begin
        merged_d = (s2_dst_q << 5) + s2_dst_q + data;
      end
      prmm_pkg::MRG_XOR33: begin
        merged_d = ((s2_dst_q ^ data) << 5) + (s2_dst_q ^ data);
      end
      prmm_pkg::MRG_ROTL: begin
        merged_d = prmm_pkg::rotl32(s2_dst_q, s2_rot_q) ^ data;
      end
      prmm_pkg::MRG_ROTR: begin
        merged_d = prmm_pkg::rotr32(s2_dst_q, s2_rot_q) ^ data;
      end
      default: begin
        merged_d = '0;
      end
    endcase
  end

  logic [W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= merged_d;
    end
  end

  assign m_axis_tdata_o = out_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // An accepted transaction occupies stage one next cycle.
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v1_q)
    else $error("accepted transaction did not reach stage one");

  // An empty first stage always takes input.
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready_o)
    else $error("input stalled with empty first stage");

  // A held item in stage two survives an output stall.
  a_s2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && v3_q && !m_axis_tready_i |=> v2_q && $stable(s2_alu_q))
    else $error("stage two item lost during stall");

  // The merge rotate amount is never zero.
  a_rot_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> s2_rot_q != '0)
    else $error("merge rotate amount is zero");

endmodule

// File: test/progpow_random_math_merge_tb.sv
`timescale 1ns / 1ps

module progpow_random_math_merge_tb;

  // One lane operation as it travels on the input stream.
  typedef struct packed {
    logic        cmd;
    logic [31:0] dst_value;
    logic [31:0] src_a;
    logic [31:0] src_b;
    logic [31:0] math_select;
    logic [31:0] merge_select;
  } lane_op_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // tdata from bit 0: dst_value, src_a, src_b, math_select, merge_select.
  logic [159:0] s_axis_tdata_i = '0;
  // tuser: cmd.
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // tdata: merged_value.
  logic [31:0]  m_axis_tdata_o;

  // Merged words still owed by the block, oldest first.
  logic [31:0]  merged_q[$];
  int unsigned  mismatch_cnt = 0;
  bit           sender_gaps = 1'b0;
  bit           receiver_stalls = 1'b0;
  int unsigned  stall_left = 0;

  progpow_random_math_merge i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Rotations with the amount already reduced to five bits.
  function automatic logic [31:0] rot_left(input logic [31:0] v, input logic [4:0] n);
    if (n == 5'd0) return v;
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] v, input logic [4:0] n);
    if (n == 5'd0) return v;
    return (v >> n) | (v << (32 - n));
  endfunction

  // Leading zeros; an all-zero word counts as 32.
  function automatic logic [31:0] lead_zero_count(input logic [31:0] v);
    logic [31:0] count;
    count = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) return count;
      count++;
    end
    return count;
  endfunction

  // New destination word for one lane operation.
  function automatic logic [31:0] predict_merged(input lane_op_t op);
    logic [31:0] data;
    logic [63:0] product;
    logic [4:0]  rot;
    product = {32'd0, op.src_a} * {32'd0, op.src_b};
    if (op.cmd) begin
      data = op.src_a;
    end else begin
      case (prmm_pkg::math_op_e'(4'(op.math_select % prmm_pkg::MathMod)))
        prmm_pkg::MOP_ADD:    data = op.src_a + op.src_b;
        prmm_pkg::MOP_MULLO:  data = product[31:0];
        prmm_pkg::MOP_MULHI:  data = product[63:32];
        prmm_pkg::MOP_MIN:    data = (op.src_a < op.src_b) ? op.src_a : op.src_b;
        prmm_pkg::MOP_ROTL:   data = rot_left(op.src_a, op.src_b[4:0]);
        prmm_pkg::MOP_ROTR:   data = rot_right(op.src_a, op.src_b[4:0]);
        prmm_pkg::MOP_AND:    data = op.src_a & op.src_b;
        prmm_pkg::MOP_OR:     data = op.src_a | op.src_b;
        prmm_pkg::MOP_XOR:    data = op.src_a ^ op.src_b;
        prmm_pkg::MOP_CLZSUM: data = lead_zero_count(op.src_a) + lead_zero_count(op.src_b);
        default:              data = 32'($countones(op.src_a)) + 32'($countones(op.src_b));
      endcase
    end
    // The merge rotate amount is always 1 to 31.
    rot = 5'(((op.merge_select >> 16) % prmm_pkg::RotMod) + 1);
    case (prmm_pkg::merge_op_e'(op.merge_select[1:0]))
      prmm_pkg::MRG_MAC33: return op.dst_value * 32'd33 + data;
      prmm_pkg::MRG_XOR33: return (op.dst_value ^ data) * 32'd33;
      prmm_pkg::MRG_ROTL:  return rot_left(op.dst_value, rot) ^ data;
      default:             return rot_right(op.dst_value, rot) ^ data;
    endcase
  endfunction

  // A math selector with the given residue and random upper bits.
  function automatic logic [31:0] math_sel_for(input prmm_pkg::math_op_e mop);
    return 32'(mop) + 32'd11 * $urandom_range(0, 390451571);
  endfunction

  // A merge selector with the given code and the given rotate field.
  function automatic logic [31:0] merge_sel_for(input prmm_pkg::merge_op_e gop,
                                                input logic [15:0] upper);
    logic [31:0] mid;
    mid = $urandom;
    return {upper, mid[15:2], 2'(gop)};
  endfunction

  function automatic lane_op_t make_op(input logic cmd, input logic [31:0] dst,
                                       input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] msel, input logic [31:0] gsel);
    lane_op_t op;
    op.cmd          = cmd;
    op.dst_value    = dst;
    op.src_a        = a;
    op.src_b        = b;
    op.math_select  = msel;
    op.merge_select = gsel;
    return op;
  endfunction

  // Operand with a bias toward the values that matter for the math.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 63);
      3:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic lane_op_t random_op();
    logic [31:0] msel;
    logic [31:0] gsel;
    msel = ($urandom_range(0, 1) == 0) ? $urandom
         : math_sel_for(prmm_pkg::math_op_e'($urandom_range(0, 10)));
    gsel = $urandom;
    // Steer the rotate field to its wrap points now and then.
    case ($urandom_range(0, 7))
      0:       gsel[31:16] = 16'd30;
      1:       gsel[31:16] = 16'd31;
      2:       gsel[31:16] = 16'hFFFF;
      default: ;
    endcase
    return make_op($urandom_range(0, 3) == 0, pick_word(), pick_word(), pick_word(),
                   msel, gsel);
  endfunction

  // Sends one transaction and records its merged word once it is taken.
  task automatic send_op(input lane_op_t op);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op.cmd;
    s_axis_tdata_i  <= {op.merge_select, op.math_select, op.src_b, op.src_a, op.dst_value};
    do @(posedge clk_i); while (!s_axis_tready_o);
    merged_q.push_back(predict_merged(op));
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (merged_q.size() != 0) @(posedge clk_i);
  endtask

  // Compares one result transaction with the oldest expected word.
  task automatic check_result(input logic [31:0] got);
    logic [31:0] want;
    if (merged_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected result %h", got);
    end else begin
      want = merged_q.pop_front();
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("merged_value: expected %h, got %h", want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
  end

  // Receiver backpressure in bursts of random length.
  always @(posedge clk_i) begin
    if (receiver_stalls && stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
      stall_left      <= $urandom_range(0, 18);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Every math operation once, with the merge codes taken in turn.
  task automatic test_math_ops();
    send_op(make_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                    math_sel_for(prmm_pkg::MOP_ADD),
                    merge_sel_for(prmm_pkg::MRG_MAC33, 16'd0)));
    send_op(make_op(1'b0, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    math_sel_for(prmm_pkg::MOP_MULLO),
                    merge_sel_for(prmm_pkg::MRG_XOR33, 16'd30)));
    send_op(make_op(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    math_sel_for(prmm_pkg::MOP_MULHI),
                    merge_sel_for(prmm_pkg::MRG_ROTL, 16'd30)));
    send_op(make_op(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    math_sel_for(prmm_pkg::MOP_MIN),
                    merge_sel_for(prmm_pkg::MRG_ROTR, 16'd0)));
    send_op(make_op(1'b0, 32'hDEAD_BEEF, 32'h8000_0001, 32'd31,
                    math_sel_for(prmm_pkg::MOP_ROTL),
                    merge_sel_for(prmm_pkg::MRG_MAC33, 16'hFFFF)));
    send_op(make_op(1'b0, 32'h0F0F_0F0F, 32'h8000_0001, 32'd33,
                    math_sel_for(prmm_pkg::MOP_ROTR),
                    merge_sel_for(prmm_pkg::MRG_XOR33, 16'd31)));
    send_op(make_op(1'b0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                    math_sel_for(prmm_pkg::MOP_AND),
                    merge_sel_for(prmm_pkg::MRG_ROTL, 16'd31)));
    send_op(make_op(1'b0, 32'd0, 32'hAAAA_AAAA, 32'h5555_5555,
                    math_sel_for(prmm_pkg::MOP_OR),
                    merge_sel_for(prmm_pkg::MRG_ROTR, 16'hFFFF)));
    send_op(make_op(1'b0, 32'hCAFE_F00D, 32'hFFFF_FFFF, 32'h0000_FFFF,
                    math_sel_for(prmm_pkg::MOP_XOR),
                    merge_sel_for(prmm_pkg::MRG_MAC33, 16'd61)));
    send_op(make_op(1'b0, 32'h0000_FFFF, 32'h0000_0001, 32'h8000_0000,
                    math_sel_for(prmm_pkg::MOP_CLZSUM),
                    merge_sel_for(prmm_pkg::MRG_XOR33, 16'd1)));
    send_op(make_op(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                    math_sel_for(prmm_pkg::MOP_POPSUM),
                    merge_sel_for(prmm_pkg::MRG_ROTL, 16'd29)));
    stop_sending();
  endtask

  // Merge-only transactions: src_b and math_select carry noise.
  task automatic test_merge_only();
    send_op(make_op(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom,
                    merge_sel_for(prmm_pkg::MRG_MAC33, 16'd0)));
    send_op(make_op(1'b1, 32'h8000_0000, 32'h0000_0001, $urandom, $urandom,
                    merge_sel_for(prmm_pkg::MRG_XOR33, 16'd30)));
    send_op(make_op(1'b1, 32'h8000_0001, 32'd0, $urandom, $urandom,
                    merge_sel_for(prmm_pkg::MRG_ROTL, 16'd30)));
    send_op(make_op(1'b1, 32'h8000_0001, 32'hFFFF_FFFF, $urandom, $urandom,
                    merge_sel_for(prmm_pkg::MRG_ROTR, 16'hFFFF)));
    stop_sending();
  endtask

  // Rotates by multiples of 32, zero operands and wrap-around arithmetic.
  task automatic test_corner_cases();
    send_op(make_op(1'b0, 32'h1357_9BDF, 32'h8765_4321, 32'd0,
                    math_sel_for(prmm_pkg::MOP_ROTL),
                    merge_sel_for(prmm_pkg::MRG_MAC33, 16'd5)));
    send_op(make_op(1'b0, 32'h1357_9BDF, 32'h8765_4321, 32'd32,
                    math_sel_for(prmm_pkg::MOP_ROTR),
                    merge_sel_for(prmm_pkg::MRG_XOR33, 16'd5)));
    send_op(make_op(1'b0, 32'h1357_9BDF, 32'h8765_4321, 32'hFFFF_FFE0,
                    math_sel_for(prmm_pkg::MOP_ROTL),
                    merge_sel_for(prmm_pkg::MRG_ROTR, 16'd7)));
    send_op(make_op(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0,
                    math_sel_for(prmm_pkg::MOP_CLZSUM),
                    merge_sel_for(prmm_pkg::MRG_MAC33, 16'd0)));
    send_op(make_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    math_sel_for(prmm_pkg::MOP_POPSUM),
                    merge_sel_for(prmm_pkg::MRG_XOR33, 16'd0)));
    send_op(make_op(1'b0, 32'h9999_9999, 32'h4444_4444, 32'h4444_4444,
                    math_sel_for(prmm_pkg::MOP_MIN),
                    merge_sel_for(prmm_pkg::MRG_ROTL, 16'd0)));
    // All-ones selectors land on the minimum and on a rotate right by two.
    send_op(make_op(1'b0, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0002,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    stop_sending();
  endtask

  task automatic test_random_stream(input int unsigned count);
    repeat (count) send_op(random_op());
    stop_sending();
  endtask

  // The sender holds off until every owed result has come back.
  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(10, 40)) send_op(random_op());
      stop_sending();
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_math_ops();
    test_merge_only();
    test_corner_cases();

    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    test_random_stream(600);
    test_drain_pause();
    test_random_stream(250);

    // Closing stretch at full rate on both sides.
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    test_random_stream(250);

    wait_drained();
    repeat (10) @(posedge clk_i);
    mismatch_cnt += merged_q.size();
    if (mismatch_cnt == 0) begin
      $display("progpow_random_math_merge_tb OK");
    end else begin
      $display("progpow_random_math_merge_tb NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("progpow_random_math_merge_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
sv/prmm_pkg.sv
sv/prmm_alu.sv
sv/progpow_random_math_merge.sv
test/progpow_random_math_merge_tb.sv
